>>> rtl/core/mtfq_pkg.sv
// ----------------------------------------------------------------------------
// mtfq_pkg
// Shared constants, codes and types of the move-to-front service queue.
// ----------------------------------------------------------------------------
package mtfq_pkg;

    // Default sizing of the list store
    localparam int CAPACITY_DEFAULT = 1024;
    localparam int ID_BITS_DEFAULT  = 20;

    // Fixed field widths of the request and result ports
    localparam int OPCODE_W    = 2;
    localparam int TARGET_ID_W = 20;
    localparam int SERVED_ID_W = 20;
    localparam int STATUS_W    = 2;
    localparam int LIST_SIZE_W = 11;

    // Reset value of the list_size register
    localparam logic [LIST_SIZE_W-1:0] LIST_SIZE_RESET = LIST_SIZE_W'(1);

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_RELOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NEXT     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EXPEDITE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // One result, as handed from the sequencer to the ports
    typedef struct packed {
        logic                   strobe;
        logic [STATUS_W-1:0]    status;
        logic [SERVED_ID_W-1:0] served_id;
    } mtfq_result_t;

endpackage

>>> rtl/core/move_to_front_service_queue.sv
// ----------------------------------------------------------------------------
// move_to_front_service_queue
// Ordered id list in a circular entry store with reload, serve-and-rotate
// and move-to-front requests; one status result per request.
// ----------------------------------------------------------------------------
//
//  channel   signals                          handshake
//  -------   ------------------------------   ----------------------------------
//  request   opcode, target_id                taken at clk edge with start & !busy
//  result    served_id, status                valid for the one cycle done is high
//  config    cfg_data (list_size)             written at clk edge with cfg_write
//
//  Unused opcodes, serve on an empty list and reload of zero ids finish
//  without touching the store; serve reads the front id and writes it at
//  the back; reload writes the clamped list_size ids in turn; expedite
//  searches, then shifts the entries ahead of the hit. The single read and
//  write port of the entry store handles one entry a cycle. busy drops in the
//  cycle done is high. Reset clears head, count and busy and loads list_size
//  with 1; the store needs no clearing. The receiver cannot stall results.
//
module move_to_front_service_queue #(
    parameter int  CAPACITY = mtfq_pkg::CAPACITY_DEFAULT,
    parameter int  ID_BITS  = mtfq_pkg::ID_BITS_DEFAULT,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mtfq_pkg::OPCODE_W-1:0]       opcode,
    input  logic [mtfq_pkg::TARGET_ID_W-1:0]    target_id,
    input  logic                                cfg_write,
    input  logic [mtfq_pkg::LIST_SIZE_W-1:0]    cfg_data,
    output logic                                done,
    output logic [mtfq_pkg::SERVED_ID_W-1:0]    served_id,
    output logic [mtfq_pkg::STATUS_W-1:0]       status
);

    logic [mtfq_pkg::LIST_SIZE_W-1:0] list_size_reg;
    logic [CW-1:0]                    load_count;
    mtfq_pkg::mtfq_result_t           result;

    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [ID_BITS-1:0]               wr_data;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic [ID_BITS-1:0]               rd_data;

    // Hold the reload size; the user must write it only while no request is in flight (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= mtfq_pkg::LIST_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            list_size_reg <= cfg_data;
        end
    end

    // Clamp the reload size to the store depth
    always_comb
    begin
        if (32'(list_size_reg) > 32'(CAPACITY))
        begin
            load_count = CW'(CAPACITY);
        end
        else
        begin
            load_count = CW'(list_size_reg);
        end
    end

    // Sequence each request over the entry store
    mtfq_seq #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .target_id  (target_id),
        .load_count (load_count),
        .busy       (busy),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // Circular store of ids, one read and one write a cycle
    mtfq_entry_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ID_BITS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Drive the result ports straight from the registered result
    assign done      = result.strobe;
    assign served_id = result.served_id;
    assign status    = result.status;

endmodule

>>> rtl/core/mtfq_entry_ram.sv
// ----------------------------------------------------------------------------
// mtfq_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtfq_entry_ram #(
    parameter int  DEPTH = mtfq_pkg::CAPACITY_DEFAULT,
    parameter int  WIDTH = mtfq_pkg::ID_BITS_DEFAULT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/mtfq_seq.sv
// ----------------------------------------------------------------------------
// mtfq_seq
// Request sequencer: keeps head and count, walks the entry store one entry
// a cycle for reload, serve, search and shift, and builds the result.
// ----------------------------------------------------------------------------
module mtfq_seq #(
    parameter int  CAPACITY = mtfq_pkg::CAPACITY_DEFAULT,
    parameter int  ID_BITS  = mtfq_pkg::ID_BITS_DEFAULT,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mtfq_pkg::OPCODE_W-1:0]       opcode,
    input  logic [mtfq_pkg::TARGET_ID_W-1:0]    target_id,
    input  logic [CW-1:0]                       load_count,
    output logic                                busy,
    output mtfq_pkg::mtfq_result_t              result,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output logic [ID_BITS-1:0]                  wr_data,
    output logic                                rd_en,
    output logic [AW-1:0]                       rd_addr,
    input  logic [ID_BITS-1:0]                  rd_data
);

    localparam int OUT_W = mtfq_pkg::SERVED_ID_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_NRD   = 3'd2;
    localparam logic [2:0] S_NWR   = 3'd3;
    localparam logic [2:0] S_SRCH  = 3'd4;
    localparam logic [2:0] S_SHRD  = 3'd5;
    localparam logic [2:0] S_SHIFT = 3'd6;
    localparam logic [2:0] S_FRONT = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [AW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [ID_BITS-1:0]              id_reg, id_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic                            res_valid_reg, res_valid_next;
    logic [mtfq_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [OUT_W-1:0]                res_served_reg, res_served_next;

    logic                            match;
    logic                            issuing;
    logic [AW-1:0]                   head_dec;

    // Physical position of a logical offset from base, modulo CAPACITY
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] ofs);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(ofs);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return AW'(s);
    endfunction

    assign match    = cmp_valid_reg && (rd_data == id_reg);
    assign issuing  = (idx_reg != count_reg);
    assign head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : (head_reg - AW'(1));

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        id_next         = id_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_served_next = res_served_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = id_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    id_next  = ID_BITS'(target_id);
                    case (opcode)
                        mtfq_pkg::OP_RELOAD:
                        begin
                            if (load_count == '0)
                            begin
                                head_next       = '0;
                                count_next      = '0;
                                res_valid_next  = 1'b1;
                                res_status_next = mtfq_pkg::ST_DONE;
                                res_served_next = '0;
                            end
                            else
                            begin
                                n_next     = load_count;
                                state_next = S_LOAD;
                            end
                        end
                        mtfq_pkg::OP_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = mtfq_pkg::ST_EMPTY;
                                res_served_next = '0;
                            end
                            else
                            begin
                                state_next = S_NRD;
                            end
                        end
                        mtfq_pkg::OP_EXPEDITE:
                        begin
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = mtfq_pkg::ST_DONE;
                            res_served_next = '0;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                wr_data = ID_BITS'(idx_reg + CW'(1));
                if ((idx_reg + CW'(1)) == n_reg)
                begin
                    head_next       = '0;
                    count_next      = n_reg;
                    res_valid_next  = 1'b1;
                    res_status_next = mtfq_pkg::ST_DONE;
                    res_served_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_NRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_NWR;
            end

            S_NWR:
            begin
                // Rotate the front id to the back
                wr_en           = 1'b1;
                wr_addr         = wrap_add(head_reg, count_reg);
                wr_data         = rd_data;
                head_next       = wrap_add(head_reg, CW'(1));
                res_valid_next  = 1'b1;
                res_status_next = mtfq_pkg::ST_SERVED;
                res_served_next = OUT_W'(rd_data);
                state_next      = S_IDLE;
            end

            S_SRCH:
            begin
                rd_en          = issuing;
                rd_addr        = wrap_add(head_reg, idx_reg);
                cmp_valid_next = issuing;
                cmp_idx_next   = AW'(idx_reg);
                if (issuing)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (match)
                begin
                    cmp_valid_next = 1'b0;
                    idx_next       = CW'(cmp_idx_reg);
                    if (cmp_idx_reg == '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = mtfq_pkg::ST_DONE;
                        res_served_next = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
                else if (!issuing)
                begin
                    res_valid_next  = 1'b1;
                    res_served_next = '0;
                    state_next      = S_IDLE;
                    if (count_reg == CW'(CAPACITY))
                    begin
                        res_status_next = mtfq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = head_dec;
                        wr_data         = id_reg;
                        head_next       = head_dec;
                        count_next      = count_reg + CW'(1);
                        res_status_next = mtfq_pkg::ST_DONE;
                    end
                end
            end

            S_SHRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = wrap_add(head_reg, idx_reg - CW'(1));
                state_next = S_SHIFT;
            end

            S_SHIFT:
            begin
                // Move one entry back while fetching the one ahead of it
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_reg, idx_reg);
                wr_data = rd_data;
                if (idx_reg == CW'(1))
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = wrap_add(head_reg, idx_reg - CW'(2));
                    idx_next = idx_reg - CW'(1);
                end
            end

            S_FRONT:
            begin
                wr_en           = 1'b1;
                wr_addr         = head_reg;
                wr_data         = id_reg;
                res_valid_next  = 1'b1;
                res_status_next = mtfq_pkg::ST_DONE;
                res_served_next = '0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        id_reg         <= id_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_served_reg <= res_served_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign result.strobe    = res_valid_reg;
    assign result.status    = res_status_reg;
    assign result.served_id = res_served_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a request is still in progress");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg != S_IDLE || res_valid_reg))
        else $error("accepted request neither started nor finished");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && rd_en) |-> (rd_addr != wr_addr))
        else $error("shift reads the entry it writes");

endmodule

>>> bench/tb_move_to_front_service_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_to_front_service_queue
// Self-checking bench for the move-to-front service queue. A behavioral copy
// of the id list predicts served_id and status for every accepted request.
// The bench runs directed corner requests and then randomized phases, each
// opened by a list_size write and a reload. Both the sender gaps and the
// list_size setting vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_move_to_front_service_queue;

    localparam int LIST_CAP      = mtfq_pkg::CAPACITY_DEFAULT;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    // Longest correct request: full search plus full shift of a full list.
    // Allow several times its length before declaring a hang.
    localparam int STALL_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 2100;
    localparam int RANDOM_ITEMS  = 520;
    localparam int PENDING_DEPTH = 16;

    // The package names no code for the fourth opcode; the block ignores it.
    localparam logic [mtfq_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [mtfq_pkg::SERVED_ID_W-1:0] served_id;
        logic [mtfq_pkg::STATUS_W-1:0]    status;
    } outcome_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [mtfq_pkg::OPCODE_W-1:0]    opcode;
    logic [mtfq_pkg::TARGET_ID_W-1:0] target_id;
    logic                             cfg_write;
    logic [mtfq_pkg::LIST_SIZE_W-1:0] cfg_data;
    logic                             done;
    logic [mtfq_pkg::SERVED_ID_W-1:0] served_id;
    logic [mtfq_pkg::STATUS_W-1:0]    status;

    // Shadow of the id list: circular store, front position, length, and the
    // list_size register as last written.
    logic [mtfq_pkg::SERVED_ID_W-1:0] list_store [LIST_CAP];
    int                               list_head;
    int                               list_count;
    logic [mtfq_pkg::LIST_SIZE_W-1:0] load_size;

    // Open requests in order: ring of predicted outcomes with running indexes
    outcome_t                         pending_outcomes [PENDING_DEPTH];
    int                               pending_wr;
    int                               pending_rd;

    int                               mismatch_count;
    int                               requests_sent;
    int                               size_settings;
    int                               longest_list;
    int                               status_seen [4];
    int                               idle_cycles;
    bit                               sender_bursting;

    move_to_front_service_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .target_id (target_id),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .done      (done),
        .served_id (served_id),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one accepted request to the shadow list and return
    // the result the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic void predict_outcome(input logic [mtfq_pkg::OPCODE_W-1:0] op,
                                            input logic [mtfq_pkg::TARGET_ID_W-1:0] id,
                                            output outcome_t want);
        int n;
        int p;
        int k;
        logic [mtfq_pkg::SERVED_ID_W-1:0] front_id;
        want.served_id = '0;
        want.status    = mtfq_pkg::ST_DONE;
        case (op)
            mtfq_pkg::OP_RELOAD:
            begin
                // Clamp the load to the store size, then fill 1..n from slot 0.
                n = (int'(load_size) > LIST_CAP) ? LIST_CAP : int'(load_size);
                for (k = 0; k < n; k++)
                    list_store[k] = mtfq_pkg::SERVED_ID_W'(k + 1);
                list_head  = 0;
                list_count = n;
            end
            mtfq_pkg::OP_NEXT:
            begin
                if (list_count == 0)
                    want.status = mtfq_pkg::ST_EMPTY;
                else
                begin
                    // Serve the front id and rotate it to the back.
                    front_id = list_store[list_head];
                    list_store[(list_head + list_count) % LIST_CAP] = front_id;
                    list_head      = (list_head + 1) % LIST_CAP;
                    want.served_id = front_id;
                    want.status    = mtfq_pkg::ST_SERVED;
                end
            end
            mtfq_pkg::OP_EXPEDITE:
            begin
                p = 0;
                while (p < list_count && list_store[(list_head + p) % LIST_CAP] != id)
                    p++;
                if (p < list_count)
                begin
                    // Hit: shift everything ahead of it back one place.
                    for (k = p; k > 0; k--)
                        list_store[(list_head + k) % LIST_CAP] =
                            list_store[(list_head + k - 1) % LIST_CAP];
                    list_store[list_head] = id;
                end
                else if (list_count >= LIST_CAP)
                    want.status = mtfq_pkg::ST_FULL;
                else
                begin
                    // Miss: grow the list at the front.
                    list_head = (list_head + LIST_CAP - 1) % LIST_CAP;
                    list_store[list_head] = id;
                    list_count++;
                end
            end
            default:
            begin
                // Unused opcode: nothing changes.
            end
        endcase
        if (list_count > longest_list)
            longest_list = list_count;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every done strobe must match the oldest open request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_wr == pending_rd)
                flag_mismatch($sformatf("result with no open request: id %0h status %0d",
                                        served_id, status));
            else
            begin
                want = pending_outcomes[pending_rd % PENDING_DEPTH];
                pending_rd++;
                status_seen[status]++;
                if (served_id !== want.served_id)
                    flag_mismatch($sformatf("served_id %0h, expected %0h",
                                            served_id, want.served_id));
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            status, want.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither a request nor a result moves.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TIMEOUT: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Called right after the previous acceptance edge: hold start
    // high for a back-to-back request, else drop it for the drawn gap.
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic [mtfq_pkg::OPCODE_W-1:0] op,
                                 input logic [mtfq_pkg::TARGET_ID_W-1:0] id);
        int gap;
        outcome_t want;
        gap = sender_bursting ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        target_id <= id;
        // Wait for the edge that takes the request.
        do
            @(posedge clk);
        while (busy);
        predict_outcome(op, id, want);
        pending_outcomes[pending_wr % PENDING_DEPTH] = want;
        pending_wr++;
        requests_sent++;
    endtask

    // Drop start and hold off until every open request has answered.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_wr != pending_rd)
            @(posedge clk);
    endtask

    // Write list_size only with the block idle.
    task automatic write_list_size(input logic [mtfq_pkg::LIST_SIZE_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        load_size = value;
        size_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Empty list after reset, insert into empty, unused opcode, reset size.
    task automatic test_empty_list_and_unused_opcode();
        issue_request(mtfq_pkg::OP_NEXT, '0);
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'hFFFFF);
        issue_request(mtfq_pkg::OP_NEXT, '0);
        issue_request(OP_UNUSED, 20'hFFFFF);
        issue_request(mtfq_pkg::OP_RELOAD, 20'hFFFFF);  // list_size still at reset value
        issue_request(mtfq_pkg::OP_NEXT, '0);
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd1);    // already at the front
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd0);    // absent, goes to the front
        issue_request(mtfq_pkg::OP_NEXT, '0);
        issue_request(mtfq_pkg::OP_NEXT, '0);
        drain_results();
    endtask

    // Empty reload, then a short list with hits in the middle and at the back.
    task automatic test_reload_sizes();
        write_list_size('0);
        issue_request(mtfq_pkg::OP_RELOAD, '0);
        issue_request(mtfq_pkg::OP_NEXT, '0);
        write_list_size(mtfq_pkg::LIST_SIZE_W'(5));
        issue_request(mtfq_pkg::OP_RELOAD, '0);
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd3);
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd5);
        issue_request(mtfq_pkg::OP_NEXT, '0);
        issue_request(mtfq_pkg::OP_NEXT, '0);
        drain_results();
    endtask

    // Oversized load clamps to a full list; inserts into it must be dropped.
    task automatic test_full_list();
        write_list_size('1);
        issue_request(mtfq_pkg::OP_RELOAD, '0);
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd1);
        issue_request(mtfq_pkg::OP_EXPEDITE, mtfq_pkg::TARGET_ID_W'(LIST_CAP));
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd2000);
        issue_request(mtfq_pkg::OP_NEXT, '0);
        write_list_size(mtfq_pkg::LIST_SIZE_W'(LIST_CAP));
        issue_request(mtfq_pkg::OP_RELOAD, '0);
        issue_request(mtfq_pkg::OP_EXPEDITE, 20'd0);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Random phases: each writes list_size, reloads, then mixes serves and
    // expedites with random content. Big lists are rare and short, since an
    // expedite there may search and shift a long list.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int counted;
        int phase_items;
        int pick;
        int k;
        int size_choice;
        logic [mtfq_pkg::TARGET_ID_W-1:0] id;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       size_choice = $urandom_range(1000, 2047);
                1:       size_choice = 0;
                2:       size_choice = $urandom_range(0, 2047);
                default: size_choice = $urandom_range(1, 24);
            endcase
            phase_items     = (size_choice > 64) ? 10 : $urandom_range(20, 45);
            sender_bursting = ($urandom_range(0, 3) == 0);
            write_list_size(mtfq_pkg::LIST_SIZE_W'(size_choice));
            issue_request(mtfq_pkg::OP_RELOAD, mtfq_pkg::TARGET_ID_W'($urandom));
            counted++;
            for (k = 0; k < phase_items; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    issue_request(mtfq_pkg::OP_RELOAD, mtfq_pkg::TARGET_ID_W'($urandom));
                    counted++;
                end
                else if (pick < 9)
                    // Ignored opcode; not counted toward the item budget.
                    issue_request(OP_UNUSED, mtfq_pkg::TARGET_ID_W'($urandom));
                else if (pick < 42)
                begin
                    issue_request(mtfq_pkg::OP_NEXT, mtfq_pkg::TARGET_ID_W'($urandom));
                    counted++;
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (list_count > 0 && pick < 55)
                        id = list_store[(list_head + $urandom_range(0, list_count - 1))
                                        % LIST_CAP];
                    else if (list_count > 0 && pick < 70)
                        id = list_store[list_head];
                    else if (pick < 85)
                        id = mtfq_pkg::TARGET_ID_W'($urandom_range(0, list_count + 8));
                    else
                        id = mtfq_pkg::TARGET_ID_W'($urandom);
                    issue_request(mtfq_pkg::OP_EXPEDITE, id);
                    counted++;
                end
            end
        end
        sender_bursting = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = mtfq_pkg::OP_RELOAD;
        target_id       = '0;
        cfg_write       = 1'b0;
        cfg_data        = '0;
        list_head       = 0;
        list_count      = 0;
        load_size       = mtfq_pkg::LIST_SIZE_RESET;
        pending_wr      = 0;
        pending_rd      = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        size_settings   = 0;
        longest_list    = 0;
        idle_cycles     = 0;
        sender_bursting = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list_and_unused_opcode();
        test_reload_sizes();
        test_full_list();
        test_random_traffic();

        // Let any stray strobe show up before closing.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_wr != pending_rd)
            flag_mismatch($sformatf("%0d requests never answered", pending_wr - pending_rd));

        $display("Ran %0d requests over %0d list_size settings, longest list %0d ids.",
                 requests_sent, size_settings, longest_list);
        $display("Results seen: %0d done, %0d served, %0d empty, %0d full drops; %0d %s",
                 status_seen[mtfq_pkg::ST_DONE], status_seen[mtfq_pkg::ST_SERVED],
                 status_seen[mtfq_pkg::ST_EMPTY], status_seen[mtfq_pkg::ST_FULL],
                 mismatch_count, "mismatches.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
